// ===== sv/tsc_pkg.sv =====
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared widths, constants and helper functions of the Taylor sine/cosine core.
// ----------------------------------------------------------------------------
package tsc_pkg;

	localparam int ANGLE_W          = 10;
	localparam int RES_W            = 32;
	localparam int TERM_W           = 64;
	localparam int TERM_FRAC        = 46;
	localparam int RESULT_FRAC_BITS = 30;
	localparam int SERIES_TERMS     = 25;
	localparam int STEPS            = SERIES_TERMS - 1;

	localparam int ANGLE_MAX     = 720;
	localparam int DEG_HALF_TURN = 180;

	localparam logic [63:0] PI_Q52  = 64'h0032_43F6_A888_5A30;
	localparam int          RAD_D   = DEG_HALF_TURN * 64;
	localparam logic [63:0] RAD_DIV = 64'(RAD_D);
	localparam logic [63:0] RAD_Q   = PI_Q52 / RAD_DIV;
	localparam logic [63:0] RAD_R   = PI_Q52 % RAD_DIV;

	localparam int R_W   = 50;
	localparam int RH_W  = R_W / 2;
	localparam int R2_W  = 2 * R_W - TERM_FRAC;
	localparam int PR_W  = ANGLE_W + $clog2(RAD_D);
	localparam int RX_S  = PR_W + $clog2(RAD_D);
	localparam logic [63:0] RX_M = (64'd1 << RX_S) / RAD_DIV + 64'd1;
	localparam int RXM_W = RX_S - $clog2(RAD_D) + 1;
	localparam int RXP_W = PR_W + RXM_W;

	localparam int DIG_W   = 18;
	localparam int NDIG    = R2_W / DIG_W;
	localparam int DIV_MAX = 2 * STEPS * (2 * STEPS + 1);
	localparam int DIV_W   = $clog2(DIV_MAX + 1);
	localparam int X_W     = DIG_W + DIV_W;
	localparam int REC_W   = X_W + 2;
	localparam int PROD_W  = X_W + REC_W;
	localparam int SH_W    = $clog2(DIG_W + 2 * DIV_W + 1);

	localparam int OUT_SHIFT = TERM_FRAC - RESULT_FRAC_BITS;
	localparam int Q_W       = TERM_W - OUT_SHIFT;

	localparam int R2_S0   = 6;
	localparam int R2_LAST = R2_S0 + 2 * (STEPS - 1);
	localparam int TERM_S0 = R2_S0 + 2 * NDIG;
	localparam int LAT     = TERM_S0 + 2 * STEPS + 2;
	localparam logic FIN_SUB = 1'(STEPS % 2);

	function automatic int sin_div(input int k);
		return (2 * k + 2) * (2 * k + 3);
	endfunction

	function automatic int cos_div(input int k);
		return (2 * k + 1) * (2 * k + 2);
	endfunction

	function automatic logic [RES_W-1:0] to_result(input logic [TERM_W-1:0] s);
		logic [Q_W-1:0] q;
		q = s[TERM_W-1:OUT_SHIFT];
		if (!q[Q_W-1] && (|q[Q_W-2:RES_W-1]))
			return {1'b0, {(RES_W-1){1'b1}}};
		else if (q[Q_W-1] && !(&q[Q_W-2:RES_W-1]))
			return {1'b1, {(RES_W-1){1'b0}}};
		return q[RES_W-1:0];
	endfunction

endpackage

// ===== sv/tsc_cdiv.sv =====
// ----------------------------------------------------------------------------
// tsc_cdiv
// Pipelined division of r squared by a fixed divisor, one digit per two stages.
// ----------------------------------------------------------------------------
module tsc_cdiv (
	input  logic                        clk,
	input  logic                        en,
	input  logic [tsc_pkg::R2_W-1:0]    dividend,
	input  logic [tsc_pkg::DIV_W-1:0]   divisor,
	input  logic [tsc_pkg::REC_W-1:0]   recip,
	input  logic [tsc_pkg::SH_W-1:0]    shift,
	output logic [tsc_pkg::R2_W-1:0]    quotient
);

	logic [tsc_pkg::X_W-1:0]    x_in   [tsc_pkg::NDIG];
	logic [tsc_pkg::DIG_W-1:0]  q_dig  [tsc_pkg::NDIG];
	logic [tsc_pkg::X_W-1:0]    x_s1   [tsc_pkg::NDIG];
	logic [tsc_pkg::PROD_W-1:0] p_s1   [tsc_pkg::NDIG];
	logic [tsc_pkg::R2_W-1:0]   num_s1 [tsc_pkg::NDIG];
	logic [tsc_pkg::R2_W-1:0]   quo_s1 [tsc_pkg::NDIG];
	logic [tsc_pkg::DIV_W-1:0]  rem_s2 [tsc_pkg::NDIG];
	logic [tsc_pkg::R2_W-1:0]   num_s2 [tsc_pkg::NDIG];
	logic [tsc_pkg::R2_W-1:0]   quo_s2 [tsc_pkg::NDIG];

	// Each step divides the running remainder with the next digit appended.
	always_comb begin
		for (int j = 0; j < tsc_pkg::NDIG; j++) begin
			if (j == 0)
				x_in[j] = {{tsc_pkg::DIV_W{1'b0}},
					dividend[(tsc_pkg::NDIG-1)*tsc_pkg::DIG_W +: tsc_pkg::DIG_W]};
			else
				x_in[j] = {rem_s2[j-1],
					num_s2[j-1][(tsc_pkg::NDIG-1-j)*tsc_pkg::DIG_W +: tsc_pkg::DIG_W]};
			q_dig[j] = tsc_pkg::DIG_W'(p_s1[j] >> shift);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < tsc_pkg::NDIG; j++) begin
				x_s1[j]   <= x_in[j];
				p_s1[j]   <= tsc_pkg::PROD_W'(x_in[j]) * tsc_pkg::PROD_W'(recip);
				num_s1[j] <= (j == 0) ? dividend : num_s2[(j == 0) ? 0 : j - 1];
				quo_s1[j] <= (j == 0) ? '0 : quo_s2[(j == 0) ? 0 : j - 1];
				rem_s2[j] <= tsc_pkg::DIV_W'(x_s1[j] -
					tsc_pkg::X_W'(q_dig[j]) * tsc_pkg::X_W'(divisor));
				num_s2[j] <= num_s1[j];
				quo_s2[j] <= (quo_s1[j] << tsc_pkg::DIG_W) | tsc_pkg::R2_W'(q_dig[j]);
			end
		end
	end

	assign quotient = quo_s2[tsc_pkg::NDIG-1];

endmodule

// ===== sv/tsc_term.sv =====
// ----------------------------------------------------------------------------
// tsc_term
// One series step: accumulates the current term and forms the next one.
// ----------------------------------------------------------------------------
module tsc_term (
	input  logic                         clk,
	input  logic                         en,
	input  logic                         subtract,
	input  logic [tsc_pkg::TERM_W-1:0]   term_in,
	input  logic [tsc_pkg::R2_W-1:0]     coef,
	input  logic [tsc_pkg::TERM_W-1:0]   sum_in,
	output logic [tsc_pkg::TERM_W-1:0]   term_out,
	output logic [tsc_pkg::TERM_W-1:0]   sum_out
);

	localparam int HALF = tsc_pkg::TERM_W / 2;
	localparam int CH_W = tsc_pkg::R2_W - HALF;
	localparam int P_W  = HALF + CH_W;
	localparam int PP_W = tsc_pkg::TERM_W + tsc_pkg::R2_W;

	logic [2*HALF-1:0]           p00_s1;
	logic [P_W-1:0]              p01_s1;
	logic [2*HALF-1:0]           p10_s1;
	logic [P_W-1:0]              p11_s1;
	logic [tsc_pkg::TERM_W-1:0]  sum_s1;
	logic [PP_W-1:0]             full;

	always_ff @(posedge clk) begin
		if (en) begin
			p00_s1 <= (2*HALF)'(term_in[HALF-1:0]) * (2*HALF)'(coef[HALF-1:0]);
			p01_s1 <= P_W'(term_in[HALF-1:0]) * P_W'(coef[tsc_pkg::R2_W-1:HALF]);
			p10_s1 <= (2*HALF)'(term_in[tsc_pkg::TERM_W-1:HALF]) * (2*HALF)'(coef[HALF-1:0]);
			p11_s1 <= P_W'(term_in[tsc_pkg::TERM_W-1:HALF]) * P_W'(coef[tsc_pkg::R2_W-1:HALF]);
			sum_s1 <= subtract ? sum_in - term_in : sum_in + term_in;
		end
	end

	assign full = PP_W'(p00_s1) + (PP_W'(p01_s1) << HALF) + (PP_W'(p10_s1) << HALF)
		+ (PP_W'(p11_s1) << (2 * HALF));

	always_ff @(posedge clk) begin
		if (en) begin
			term_out <= full[tsc_pkg::TERM_FRAC +: tsc_pkg::TERM_W];
			sum_out  <= sum_s1;
		end
	end

endmodule

// ===== sv/taylor_sine_cosine.sv =====
// ----------------------------------------------------------------------------
// taylor_sine_cosine
// Sine and cosine of an angle in whole degrees by 25-term Taylor series.
//
//   channel   signals                                   role
//   input     in_valid, in_ready, angle_deg             angle, 0..720 degrees
//   output    out_valid, out_ready, sine_value,         Q1.30 results
//             cosine_value
//
// One angle is taken per cycle while in_ready is high; each result passes through
// the degree-to-radian scaling, the squaring of r, the digit dividers and the
// two-stage multiply/accumulate chain of the series steps, all registered.
// Reset clears only the valid bits. The whole pipeline holds while a result
// waits on out_ready, so in_ready is low exactly then.
// ----------------------------------------------------------------------------
module taylor_sine_cosine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [tsc_pkg::ANGLE_W-1:0]   angle_deg,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [tsc_pkg::RES_W-1:0] sine_value,
	output logic signed [tsc_pkg::RES_W-1:0] cosine_value
);

	logic                          adv;
	logic                          vld_s [1:tsc_pkg::LAT];
	logic [tsc_pkg::ANGLE_W-1:0]   deg_s1;
	logic [tsc_pkg::R_W-1:0]       pq_s2;
	logic [tsc_pkg::PR_W-1:0]      pr_s2;
	logic [tsc_pkg::R_W-1:0]       pq_s3;
	logic [tsc_pkg::RXP_W-1:0]     rxm_s3;
	logic [tsc_pkg::R_W-1:0]       r_s [4:tsc_pkg::TERM_S0];
	logic [tsc_pkg::R_W-1:0]       rll_s5;
	logic [tsc_pkg::R_W-1:0]       rlh_s5;
	logic [tsc_pkg::R_W-1:0]       rhh_s5;
	logic [2*tsc_pkg::R_W-1:0]     r2_full;
	logic [tsc_pkg::R2_W-1:0]      r2_s [tsc_pkg::R2_S0:tsc_pkg::R2_LAST];
	logic [tsc_pkg::R2_W-1:0]      csin [tsc_pkg::STEPS];
	logic [tsc_pkg::R2_W-1:0]      ccos [tsc_pkg::STEPS];
	logic [tsc_pkg::TERM_W-1:0]    tsin [tsc_pkg::STEPS+1];
	logic [tsc_pkg::TERM_W-1:0]    ssin [tsc_pkg::STEPS+1];
	logic [tsc_pkg::TERM_W-1:0]    tcos [tsc_pkg::STEPS+1];
	logic [tsc_pkg::TERM_W-1:0]    scos [tsc_pkg::STEPS+1];
	logic [tsc_pkg::TERM_W-1:0]    sin_acc_sf;
	logic [tsc_pkg::TERM_W-1:0]    cos_acc_sf;

	assign adv       = !vld_s[tsc_pkg::LAT] || out_ready;
	assign in_ready  = adv;
	assign out_valid = vld_s[tsc_pkg::LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 1; p <= tsc_pkg::LAT; p++)
				vld_s[p] <= 1'b0;
		end else if (adv) begin
			vld_s[1] <= in_valid;
			for (int p = 2; p <= tsc_pkg::LAT; p++)
				vld_s[p] <= vld_s[p-1];
		end
	end

	assign r2_full = {rhh_s5, {tsc_pkg::R_W{1'b0}}}
		+ ((2*tsc_pkg::R_W)'(rlh_s5) << (tsc_pkg::RH_W + 1))
		+ (2*tsc_pkg::R_W)'(rll_s5);

	always_ff @(posedge clk) begin
		if (adv) begin
			deg_s1 <= (angle_deg > tsc_pkg::ANGLE_W'(tsc_pkg::ANGLE_MAX))
				? tsc_pkg::ANGLE_W'(tsc_pkg::ANGLE_MAX) : angle_deg;
			pq_s2  <= tsc_pkg::R_W'(deg_s1) * tsc_pkg::RAD_Q[tsc_pkg::R_W-1:0];
			pr_s2  <= tsc_pkg::PR_W'(deg_s1) * tsc_pkg::RAD_R[tsc_pkg::PR_W-1:0];
			pq_s3  <= pq_s2;
			rxm_s3 <= tsc_pkg::RXP_W'(pr_s2) * tsc_pkg::RX_M[tsc_pkg::RXP_W-1:0];
			r_s[4] <= pq_s3 + tsc_pkg::R_W'(rxm_s3 >> tsc_pkg::RX_S);
			for (int p = 5; p <= tsc_pkg::TERM_S0; p++)
				r_s[p] <= r_s[p-1];
			rll_s5 <= tsc_pkg::R_W'(r_s[4][tsc_pkg::RH_W-1:0])
				* tsc_pkg::R_W'(r_s[4][tsc_pkg::RH_W-1:0]);
			rlh_s5 <= tsc_pkg::R_W'(r_s[4][tsc_pkg::RH_W-1:0])
				* tsc_pkg::R_W'(r_s[4][tsc_pkg::R_W-1:tsc_pkg::RH_W]);
			rhh_s5 <= tsc_pkg::R_W'(r_s[4][tsc_pkg::R_W-1:tsc_pkg::RH_W])
				* tsc_pkg::R_W'(r_s[4][tsc_pkg::R_W-1:tsc_pkg::RH_W]);
			r2_s[tsc_pkg::R2_S0] <= r2_full[2*tsc_pkg::R_W-1:tsc_pkg::TERM_FRAC];
			for (int p = tsc_pkg::R2_S0 + 1; p <= tsc_pkg::R2_LAST; p++)
				r2_s[p] <= r2_s[p-1];
			sin_acc_sf <= tsc_pkg::FIN_SUB ? ssin[tsc_pkg::STEPS] - tsin[tsc_pkg::STEPS]
				: ssin[tsc_pkg::STEPS] + tsin[tsc_pkg::STEPS];
			cos_acc_sf <= tsc_pkg::FIN_SUB ? scos[tsc_pkg::STEPS] - tcos[tsc_pkg::STEPS]
				: scos[tsc_pkg::STEPS] + tcos[tsc_pkg::STEPS];
			sine_value   <= tsc_pkg::to_result(sin_acc_sf);
			cosine_value <= tsc_pkg::to_result(cos_acc_sf);
		end
	end

	assign tsin[0] = tsc_pkg::TERM_W'(r_s[tsc_pkg::TERM_S0]);
	assign ssin[0] = '0;
	assign tcos[0] = tsc_pkg::TERM_W'(1) << tsc_pkg::TERM_FRAC;
	assign scos[0] = '0;

	for (genvar k = 0; k < tsc_pkg::STEPS; k++) begin : g_step
		localparam int DSIN = tsc_pkg::sin_div(k);
		localparam int DCOS = tsc_pkg::cos_div(k);
		localparam int SH_SIN = tsc_pkg::DIG_W + 2 * $clog2(DSIN);
		localparam int SH_COS = tsc_pkg::DIG_W + 2 * $clog2(DCOS);
		localparam logic [63:0] M_SIN = (64'd1 << SH_SIN) / 64'(DSIN) + 64'd1;
		localparam logic [63:0] M_COS = (64'd1 << SH_COS) / 64'(DCOS) + 64'd1;

		tsc_cdiv u_div_sin (
			.clk      (clk),
			.en       (adv),
			.dividend (r2_s[tsc_pkg::R2_S0 + 2 * k]),
			.divisor  (tsc_pkg::DIV_W'(DSIN)),
			.recip    (M_SIN[tsc_pkg::REC_W-1:0]),
			.shift    (tsc_pkg::SH_W'(SH_SIN)),
			.quotient (csin[k])
		);

		tsc_cdiv u_div_cos (
			.clk      (clk),
			.en       (adv),
			.dividend (r2_s[tsc_pkg::R2_S0 + 2 * k]),
			.divisor  (tsc_pkg::DIV_W'(DCOS)),
			.recip    (M_COS[tsc_pkg::REC_W-1:0]),
			.shift    (tsc_pkg::SH_W'(SH_COS)),
			.quotient (ccos[k])
		);

		tsc_term u_term_sin (
			.clk      (clk),
			.en       (adv),
			.subtract (1'(k % 2)),
			.term_in  (tsin[k]),
			.coef     (csin[k]),
			.sum_in   (ssin[k]),
			.term_out (tsin[k+1]),
			.sum_out  (ssin[k+1])
		);

		tsc_term u_term_cos (
			.clk      (clk),
			.en       (adv),
			.subtract (1'(k % 2)),
			.term_in  (tcos[k]),
			.coef     (ccos[k]),
			.sum_in   (scos[k]),
			.term_out (tcos[k+1]),
			.sum_out  (scos[k+1])
		);
	end

endmodule

// ===== sv/tsc_checker.sv =====
// ----------------------------------------------------------------------------
// tsc_checker
// Port-level checks of the Taylor sine/cosine core, bound to its top level.
// ----------------------------------------------------------------------------
module tsc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic signed [tsc_pkg::RES_W-1:0] sine_value,
	input logic signed [tsc_pkg::RES_W-1:0] cosine_value
);

	localparam logic signed [tsc_pkg::RES_W-1:0] LIM =
		tsc_pkg::RES_W'((64'd1 << tsc_pkg::RESULT_FRAC_BITS) + 64'd4096);

	// A result that is held back freezes the whole pipeline.
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while a result is stalled");

	a_empty_takes_input: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input refused with the output stage empty");

	a_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sine_value)
			&& $stable(cosine_value))
		else $error("stalled result changed or dropped");

	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sine_value <= LIM && sine_value >= -LIM
			&& cosine_value <= LIM && cosine_value >= -LIM)
		else $error("result outside the unit range");

endmodule

bind taylor_sine_cosine tsc_checker u_tsc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.sine_value   (sine_value),
	.cosine_value (cosine_value)
);
